[rtl/packet_framer_fletcher16_top_defines.svh]
// ----------------------------------------------------------------------------
// Packet framer defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAMER_FLETCHER16_TOP_DEFINES_SVH
`define PACKET_FRAMER_FLETCHER16_TOP_DEFINES_SVH

// clocked assertion, masked while reset is held
`define PFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define PFF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/pff_pkg.sv]
// ----------------------------------------------------------------------------
// Packet framer package
// Item types, frame job layout, register codes and the mod-255 adder.
// ----------------------------------------------------------------------------
package pff_pkg;

  localparam int unsigned IN_TDATA_W = 40;
  localparam int unsigned IN_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W  = 8;

  // frame job slots: six header bytes, one payload byte, two trailer bytes
  localparam int unsigned HDR_BYTES = 6;
  localparam int unsigned JOB_BYTES = 9;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h37;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h01;
  localparam logic [7:0] MOD_BASE        = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 8'd0,
    REG_SYNC_SECOND = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  msg_id;
    logic [7:0]  sub_id;
    logic [15:0] declared_length;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        start_of_packet;
    logic        end_of_packet;
  } item_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } cfg_t;

  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [JOB_BYTES-1:0]      mask;
  } job_t;

  // first operand is a sum below 255, so one conditional subtract is enough
  function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MOD_BASE}) begin
      s = s - {1'b0, MOD_BASE};
    end
    return s[7:0];
  endfunction

endpackage

[rtl/pff_in_stage.sv]
// ----------------------------------------------------------------------------
// Packet framer input stage
// One-entry input register; takes an item while the frame job is busy.
// ----------------------------------------------------------------------------
module pff_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  pff_pkg::item_t s_item_i,
  input  logic          take_i,
  output logic          valid_o,
  output pff_pkg::item_t item_o
);
  import pff_pkg::*;

  logic  valid_d, valid_q;
  item_t item_q;

  assign s_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/pff_frame_build.sv]
// ----------------------------------------------------------------------------
// Packet framer frame builder
// Holds the Fletcher-16 sums and lays out the bytes one item produces.
// ----------------------------------------------------------------------------
module pff_frame_build (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  pff_pkg::item_t item_i,
  input  pff_pkg::cfg_t  cfg_i,
  output pff_pkg::job_t  job_o
);
  import pff_pkg::*;

  logic [7:0] sum_low_q, sum_high_q;
  logic [7:0] sum_low_d, sum_high_d;
  logic [7:0] base_low, base_high;

  // a start item clears the sums before its own payload byte is folded in
  assign base_low  = item_i.start_of_packet ? 8'd0 : sum_low_q;
  assign base_high = item_i.start_of_packet ? 8'd0 : sum_high_q;

  always_comb begin
    sum_low_d  = base_low;
    sum_high_d = base_high;
    if (item_i.byte_valid) begin
      sum_low_d  = mod255_add(base_low, item_i.data_byte);
      sum_high_d = mod255_add(base_high, sum_low_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_low_q  <= 8'd0;
      sum_high_q <= 8'd0;
    end else if (load_i) begin
      sum_low_q  <= sum_low_d;
      sum_high_q <= sum_high_d;
    end
  end

  always_comb begin
    job_o.bytes[0] = cfg_i.sync_first;
    job_o.bytes[1] = cfg_i.sync_second;
    job_o.bytes[2] = item_i.msg_id;
    job_o.bytes[3] = item_i.sub_id;
    job_o.bytes[4] = item_i.declared_length[7:0];
    job_o.bytes[5] = item_i.declared_length[15:8];
    job_o.bytes[6] = item_i.data_byte;
    job_o.bytes[7] = sum_low_d;
    job_o.bytes[8] = sum_high_d;
    job_o.mask     = {{2{item_i.end_of_packet}}, item_i.byte_valid,
                      {HDR_BYTES{item_i.start_of_packet}}};
  end

endmodule

[rtl/pff_serializer.sv]
// ----------------------------------------------------------------------------
// Packet framer serialiser
// Frame job register; sends the lowest pending byte on each ready cycle.
// ----------------------------------------------------------------------------
module pff_serializer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  pff_pkg::job_t job_i,
  input  logic          m_ready_i,
  output logic          m_valid_o,
  output logic [7:0]    m_data_o,
  output logic          m_last_o,
  output logic          free_o
);
  import pff_pkg::*;

  localparam logic [JOB_BYTES-1:0] ONE = JOB_BYTES'(1);

  logic [JOB_BYTES-1:0]      mask_q, mask_d;
  logic [JOB_BYTES-1:0][7:0] bytes_q;
  logic [JOB_BYTES-1:0]      pick;
  logic                      active, last;

  assign active = |mask_q;
  assign pick   = mask_q & (~mask_q + ONE);
  assign last   = active && ((mask_q & (mask_q - ONE)) == '0);
  assign free_o = !active || (m_ready_i && last);

  always_comb begin
    m_data_o = 8'd0;
    for (int i = 0; i < JOB_BYTES; i++) begin
      m_data_o = m_data_o | (bytes_q[i] & {8{pick[i]}});
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = job_i.mask;
    end else if (active && m_ready_i) begin
      mask_d = mask_q & ~pick;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= job_i.bytes;
    end
  end

  assign m_valid_o = active;
  assign m_last_o  = last;

endmodule

[rtl/packet_framer_fletcher16_top.sv]
// ----------------------------------------------------------------------------
// Packet framer with Fletcher-16 trailer
// Frames payload bytes with a six-byte header and a two-byte checksum.
// ----------------------------------------------------------------------------
// Each accepted item turns into up to nine output bytes, sent one per cycle on
// the single output port while it is ready: header (6) on a start item, the
// payload byte when valid, then sum1 and sum2 on an end item; tlast marks the
// item's last byte. Items stream back to back; a start item adds the header and
// an end item the trailer. An item that sets none of its flags gives no bytes.
// An item is registered in the input stage, then in the serialiser's job
// register, before its first byte appears. The user must write sync bytes
// through the configuration port while the block is idle; it is not enforced.
module packet_framer_fletcher16_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // item in
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // msg_id[7:0], sub_id[15:8], declared_length[31:16], data_byte[39:32]
  input  logic [pff_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // byte_valid[0], start_of_packet[1]
  input  logic [pff_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,   // end_of_packet
  // framed bytes out
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [7:0]                       m_axis_tdata_o,   // out_byte[7:0]
  output logic                             m_axis_tlast_o,   // end_of_run
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pff_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [7:0]                       cfg_data_i
);
  import pff_pkg::*;

  item_t s_item, in_item;
  cfg_t  cfg_q;
  job_t  job;
  logic  in_valid, job_free, load;

  assign s_item.msg_id          = s_axis_tdata_i[7:0];
  assign s_item.sub_id          = s_axis_tdata_i[15:8];
  assign s_item.declared_length = s_axis_tdata_i[31:16];
  assign s_item.data_byte       = s_axis_tdata_i[39:32];
  assign s_item.byte_valid      = s_axis_tuser_i[0];
  assign s_item.start_of_packet = s_axis_tuser_i[1];
  assign s_item.end_of_packet   = s_axis_tlast_i;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_SYNC_FIRST) begin
        cfg_q.sync_first <= cfg_data_i;
      end else if (cfg_index_i == REG_SYNC_SECOND) begin
        cfg_q.sync_second <= cfg_data_i;
      end
    end
  end

  assign load = in_valid && job_free;

  pff_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_item_i  (s_item),
    .take_i    (load),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  pff_frame_build u_frame_build (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .item_i (in_item),
    .cfg_i  (cfg_q),
    .job_o  (job)
  );

  pff_serializer u_serializer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .job_i     (job),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o),
    .free_o    (job_free)
  );

endmodule

[rtl/pff_checker.sv]
// ----------------------------------------------------------------------------
// Packet framer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_framer_fletcher16_top_defines.svh"

module pff_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic m_axis_tlast_o
);

  // stalled output byte holds
  `PFF_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output byte changed while stalled")

  // bytes of one item follow without a gap
  `PFF_ASSERT(a_run_gapless, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o, "gap inside a run")

  // input only backs up behind pending output
  `PFF_ASSERT(a_ready_backpressure, !s_axis_tready_o |-> m_axis_tvalid_o, "input stalled with output idle")

  // output is idle on the edge after reset has been seen
  `PFF_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid_o, "output valid during reset")

endmodule

bind packet_framer_fletcher16_top pff_checker u_pff_checker (.*);

[dv/packet_framer_fletcher16_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet framer Fletcher-16 testbench
// A queue-fed driver sends payload items. A monitor checks each framed byte
// and its tlast against a local framing and checksum predictor. The run goes
// through four sync settings with different idle and stall mixes.
// ----------------------------------------------------------------------------
module packet_framer_fletcher16_top_test;
  import pff_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RST_CYCLES      = 8;
  localparam int SETTLE_CYCLES   = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 93;
  localparam int FLETCHER_MOD    = 255;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    cfg_reg_e   idx;
    logic [7:0] data;
  } reg_write_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  s_valid   = 1'b0;
  logic                  s_ready;
  logic [IN_TDATA_W-1:0] s_data    = '0;
  logic [IN_TUSER_W-1:0] s_user    = '0;
  logic                  s_last    = 1'b0;
  logic                  m_valid;
  logic                  m_ready   = 1'b0;
  logic [7:0]            m_data;
  logic                  m_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = REG_SYNC_FIRST;
  logic [7:0]            cfg_data  = '0;

  item_t       pending_items[$];
  reg_write_t  pending_writes[$];
  frame_byte_t framed_q[$];

  // predictor state
  logic [7:0] sync_a = SYNC_FIRST_RST;
  logic [7:0] sync_b = SYNC_SECOND_RST;
  logic [7:0] sum_lo = '0;
  logic [7:0] sum_hi = '0;

  int src_idle_pct   = 0;
  int snk_stall_pct  = 0;
  int errors         = 0;
  int items_queued   = 0;
  int packets_queued = 0;
  int bytes_checked  = 0;
  int settings_used  = 1;
  int cycle_cnt      = 0;

  packet_framer_fletcher16_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Regression FAIL");
      $finish;
    end
  end

  // header, payload byte and trailer that one item turns into
  task automatic frame_item(input item_t it);
    frame_byte_t burst[$];
    if (it.start_of_packet) begin
      sum_lo = '0;
      sum_hi = '0;
      burst.insert(burst.size(), '{sync_a, 1'b0});
      burst.insert(burst.size(), '{sync_b, 1'b0});
      burst.insert(burst.size(), '{it.msg_id, 1'b0});
      burst.insert(burst.size(), '{it.sub_id, 1'b0});
      burst.insert(burst.size(), '{it.declared_length[7:0], 1'b0});
      burst.insert(burst.size(), '{it.declared_length[15:8], 1'b0});
    end
    if (it.byte_valid) begin
      sum_lo = 8'((int'(sum_lo) + int'(it.data_byte)) % FLETCHER_MOD);
      sum_hi = 8'((int'(sum_hi) + int'(sum_lo)) % FLETCHER_MOD);
      burst.insert(burst.size(), '{it.data_byte, 1'b0});
    end
    if (it.end_of_packet) begin
      burst.insert(burst.size(), '{sum_lo, 1'b0});
      burst.insert(burst.size(), '{sum_hi, 1'b0});
    end
    if (burst.size() != 0) begin
      burst[burst.size()-1].last = 1'b1;
    end
    foreach (burst[i]) framed_q.insert(framed_q.size(), burst[i]);
  endtask

  // item driver
  always @(posedge clk_i or negedge rst_ni) begin
    item_t nxt;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= '0;
      s_last  <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = pending_items.pop_front();
        s_valid <= 1'b1;
        s_data  <= {nxt.data_byte, nxt.declared_length, nxt.sub_id, nxt.msg_id};
        s_user  <= {nxt.start_of_packet, nxt.byte_valid};
        s_last  <= nxt.end_of_packet;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t w;
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (pending_writes.size() != 0) begin
        w = pending_writes.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= w.idx;
        cfg_data  <= w.data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // predictor and byte checker
  always @(posedge clk_i) begin
    item_t       seen;
    frame_byte_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYNC_FIRST:  sync_a = cfg_data;
          REG_SYNC_SECOND: sync_b = cfg_data;
          default: ;
        endcase
      end
      if (s_valid && s_ready) begin
        seen.msg_id          = s_data[7:0];
        seen.sub_id          = s_data[15:8];
        seen.declared_length = s_data[31:16];
        seen.data_byte       = s_data[39:32];
        seen.byte_valid      = s_user[0];
        seen.start_of_packet = s_user[1];
        seen.end_of_packet   = s_last;
        frame_item(seen);
      end
      if (m_valid && m_ready) begin
        bytes_checked++;
        if (framed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, m_data, m_last);
        end else begin
          want = framed_q.pop_front();
          if (m_data !== want.val) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.val, m_data);
          end
          if (m_last !== want.last) begin
            errors++;
            $display("%0t: end_of_run mismatch: expected %0b, actual %0b",
                     $time, want.last, m_last);
          end
        end
      end
    end
  end

  function automatic item_t mk_item(input logic [7:0] msg, input logic [7:0] sub,
                                    input logic [15:0] len, input logic [7:0] dat,
                                    input logic v, input logic st, input logic en);
    item_t it;
    it.msg_id          = msg;
    it.sub_id          = sub;
    it.declared_length = len;
    it.data_byte       = dat;
    it.byte_valid      = v;
    it.start_of_packet = st;
    it.end_of_packet   = en;
    return it;
  endfunction

  function automatic item_t rnd_item(input logic v, input logic st, input logic en);
    return mk_item(8'($urandom()), 8'($urandom()), 16'($urandom()), 8'($urandom()),
                   v, st, en);
  endfunction

  task automatic post(input item_t it);
    pending_items.insert(pending_items.size(), it);
    items_queued++;
    if (it.start_of_packet) packets_queued++;
  endtask

  // mostly well-formed packets with random content, some noise
  task automatic gen_packet();
    int          n;
    logic        lead_v;
    logic        tail_v;
    logic [15:0] len;
    if ($urandom_range(0, 9) == 0) begin
      post(rnd_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
    end else begin
      n      = $urandom_range(0, 12);
      lead_v = 1'($urandom_range(0, 1));
      tail_v = 1'($urandom_range(0, 1));
      len    = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'(n + lead_v + tail_v);
      post(mk_item(8'($urandom()), 8'($urandom()), len, 8'($urandom()), lead_v, 1'b1, 1'b0));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) post(rnd_item(1'b0, 1'b0, 1'b0));
        post(rnd_item(1'b1, 1'b0, 1'b0));
      end
      // now and then the packet stays open and the next start restarts it
      if ($urandom_range(0, 11) != 0) post(rnd_item(tail_v, 1'b0, 1'b1));
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
    pending_writes.insert(pending_writes.size(), '{idx, val});
    do @(negedge clk_i); while (pending_writes.size() != 0 || cfg_valid);
  endtask

  // hold off until every item is in and every byte is out
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_valid || framed_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          write_reg(REG_SYNC_FIRST, 8'h00);
          write_reg(REG_SYNC_SECOND, 8'hFF);
          src_idle_pct  = 47;
          snk_stall_pct = 0;
        end
        2: begin
          write_reg(REG_SYNC_FIRST, 8'hFF);
          write_reg(REG_SYNC_SECOND, 8'h00);
          src_idle_pct  = 0;
          snk_stall_pct = 47;
        end
        default: begin
          write_reg(REG_SYNC_FIRST, 8'($urandom()));
          write_reg(REG_SYNC_SECOND, 8'($urandom()));
          src_idle_pct  = 25;
          snk_stall_pct = 25;
        end
      endcase
      if (ph != 0) settings_used++;

      if (ph == 0) begin
        post(mk_item(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 1'b0)); // idle
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b1)); // empty packet
        post(mk_item(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 1'b0));
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0, 1'b0));
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'hFE, 1'b1, 1'b0, 1'b0));
        post(mk_item(8'h12, 8'h34, 16'h5678, 8'hAB, 1'b0, 1'b0, 1'b0)); // byte ignored
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1));
        // bytes after an end keep folding into the open sums
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h80, 1'b1, 1'b0, 1'b0));
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0, 1'b1));
        // declared length 3, five bytes sent
        post(mk_item(8'hA5, 8'h5A, 16'h0003, 8'h01, 1'b1, 1'b1, 1'b0));
        for (int i = 2; i <= 5; i++) post(mk_item('0, '0, '0, 8'(i), 1'b1, 1'b0, 1'b0));
        // restart inside an open packet
        post(mk_item(8'hC3, 8'h3C, 16'h0002, 8'h77, 1'b1, 1'b1, 1'b0));
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h99, 1'b1, 1'b0, 1'b1));
        post(mk_item(8'h5A, 8'hA5, 16'h0102, 8'hE1, 1'b1, 1'b1, 1'b1)); // nine bytes
        post(mk_item(8'h01, 8'h02, 16'h0000, 8'h00, 1'b0, 1'b1, 1'b0));
        post(mk_item(8'h00, 8'h00, 16'h0000, 8'h7F, 1'b0, 1'b0, 1'b1));
      end

      while (items_queued < ITEMS_PER_PHASE * (ph + 1)) gen_packet();
      drain();
    end

    errors += framed_q.size();
    $display("Sent %0d items in %0d packets under %0d sync settings;", items_queued,
             packets_queued, settings_used);
    $display("checked %0d framed bytes with idle and stall mixes up to 47 in 100.",
             bytes_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/pff_pkg.sv
rtl/pff_in_stage.sv
rtl/pff_frame_build.sv
rtl/pff_serializer.sv
rtl/packet_framer_fletcher16_top.sv
rtl/pff_checker.sv
dv/packet_framer_fletcher16_top_test.sv
